>>> hdl/qma_pkg.sv
// shared types and constants for the quaternion moving average
`default_nettype none
package qma_pkg;
    localparam int WINDOW_DEF = 200;
    localparam int COMP_W     = 16;
    localparam int QUO_W      = 17;   // quotient bits, magnitude never exceeds 32768
    localparam int NORM_BIT   = 24;   // normalized max magnitude reaches 2^24

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_UPDATE,
        LN_LOAD,
        LN_SHIFT,
        LN_SQUARE,
        LN_DIV_START,
        LN_DIV_STEP
    } lane_op_t;
endpackage
`default_nettype wire

>>> hdl/quaternion_moving_average.sv
// top level: sliding window quaternion sum, normalized to unit length
//
//  channel  dir  signals                       contents
//  s        in   s_tvalid s_tready s_tdata     sample quaternion x,y,z,w
//  m        out  m_tvalid m_tready m_tdata     unit quaternion x,y,z,w
//                m_tuser                       zero_sum flag
//
// one beat in flight at a time; the work per beat is the one-bit-a-cycle
// normalize shift, the bit-serial root and the serial divide; an all-zero
// sum goes straight to the output. reset clears sums, pointer and fill
// flag; slots not yet written read as zero. a stalled result waits in the
// output register while the next beat is already accepted.
`default_nettype none
module quaternion_moving_average #(
    parameter int WINDOW = qma_pkg::WINDOW_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // x, y, z, w (16 bits each)
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // out_x, out_y, out_z, out_w (16 bits each)
    output logic      [0:0]  m_tuser    // zero_sum
);
    import qma_pkg::*;

    localparam int SUM_W = COMP_W + $clog2(WINDOW);
    localparam int NW    = (SUM_W > NORM_BIT + 1) ? SUM_W : NORM_BIT + 1;
    localparam int RW    = NW + 1;
    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW    = $clog2(QUO_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_NORM,
        ST_SQUARE,
        ST_ADD,
        ST_ROOT,
        ST_DIV_START,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic            full_reg, full_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            zflag_reg, zflag_next;
    logic [63:0]     smp_reg, smp_next;
    logic            mvalid_reg, mvalid_next;
    logic [63:0]     mdata_reg, mdata_next;
    logic            muser_reg, muser_next;

    lane_op_t        op;
    logic [63:0]     rdata, old;
    logic            ram_we, root_start, root_done;
    logic [3:0]      high, szero;
    logic [2*NW-1:0] sq [4];
    logic [15:0]     res [4];
    logic [2*RW-1:0] nsum;
    logic [RW-1:0]   len;

    qma_ram #(.W(64), .DEPTH(WINDOW), .AW(AW)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (smp_reg),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    // before the first wrap the slot at the pointer has never been written
    assign old = full_reg ? rdata : '0;

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        qma_lane #(.SUM_W(SUM_W), .NW(NW), .RW(RW)) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (op),
            .smp      (smp_reg[16*g +: 16]),
            .old      (old[16*g +: 16]),
            .len      (len),
            .high     (high[g]),
            .sum_zero (szero[g]),
            .sq       (sq[g]),
            .res      (res[g])
        );
    end

    assign nsum = (2*RW)'(sq[0]) + (2*RW)'(sq[1]) + (2*RW)'(sq[2]) + (2*RW)'(sq[3]);

    qma_root #(.RW(RW)) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .n     (nsum),
        .len   (len),
        .done  (root_done)
    );

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        full_next   = full_reg;
        cnt_next    = cnt_reg;
        zflag_next  = zflag_reg;
        smp_next    = smp_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        op          = LN_IDLE;
        ram_we      = 1'b0;
        root_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    smp_next   = s_tdata;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                op     = LN_UPDATE;
                ram_we = 1'b1;
                if (ptr_reg == AW'(WINDOW - 1))
                begin
                    ptr_next  = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                op         = LN_LOAD;
                zflag_next = &szero;
                state_next = (&szero) ? ST_OUT : ST_NORM;
            end
            ST_NORM:
            begin
                if (|high)
                begin
                    state_next = ST_SQUARE;
                end
                else
                begin
                    op = LN_SHIFT;
                end
            end
            ST_SQUARE:
            begin
                op         = LN_SQUARE;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                op         = LN_DIV_START;
                cnt_next   = CW'(QUO_W);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                op       = LN_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    muser_next  = zflag_reg;
                    mdata_next  = zflag_reg ? '0 : {res[3], res[2], res[1], res[0]};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ptr_reg    <= '0;
            full_reg   <= 1'b0;
            cnt_reg    <= '0;
            zflag_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            full_reg   <= full_next;
            cnt_reg    <= cnt_next;
            zflag_reg  <= zflag_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_READ)
        else $error("accepted beat did not start the store read");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero sum result carries nonzero data");

    a_root_norm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROOT && root_done |=> len[RW-1:NORM_BIT] != '0)
        else $error("root of normalized sum below 2^24");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= AW'(WINDOW - 1))
        else $error("write pointer beyond window");
endmodule
`default_nettype wire

>>> hdl/qma_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module qma_ram #(
    parameter int W     = 64,
    parameter int DEPTH = 200,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hdl/qma_lane.sv
// one component lane: running sum, normalize shift, square and serial divide
`default_nettype none
module qma_lane #(
    parameter int SUM_W = 24,
    parameter int NW    = 25,
    parameter int RW    = 26
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire qma_pkg::lane_op_t       op,
    input  wire logic signed [15:0]      smp,
    input  wire logic signed [15:0]      old,
    input  wire logic        [RW-1:0]    len,
    output logic                         high,
    output logic                         sum_zero,
    output logic             [2*NW-1:0]  sq,
    output logic signed      [15:0]      res
);
    import qma_pkg::*;

    localparam int NUM_W = NW + QUO_W;
    localparam int DV_W  = RW + 1;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [NW-1:0]           mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [2*NW-1:0]         sq_reg, sq_next;
    logic [DV_W-1:0]         rem_reg, rem_next;
    logic [QUO_W-1:0]        nlow_reg, nlow_next;
    logic [QUO_W-1:0]        q_reg, q_next;

    logic signed [SUM_W-1:0] smp_ext, old_ext;
    logic [SUM_W-1:0]        abs_val;
    logic [NUM_W-1:0]        num;
    logic [DV_W:0]           trial, dvs;
    logic                    ge;
    logic [QUO_W-1:0]        q_sat;

    assign smp_ext = SUM_W'(smp);
    assign old_ext = SUM_W'(old);
    assign abs_val = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign num     = (NUM_W'(mag_reg) << 16) + NUM_W'(len);
    assign dvs     = (DV_W + 1)'({len, 1'b0});
    assign trial   = {rem_reg, nlow_reg[QUO_W-1]};
    assign ge      = trial >= dvs;

    always_comb
    begin
        sum_next  = sum_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        sq_next   = sq_reg;
        rem_next  = rem_reg;
        nlow_next = nlow_reg;
        q_next    = q_reg;
        case (op)
            LN_UPDATE:
            begin
                sum_next = sum_reg + smp_ext - old_ext;
            end
            LN_LOAD:
            begin
                mag_next = NW'(abs_val);
                neg_next = sum_reg[SUM_W-1];
            end
            LN_SHIFT:
            begin
                mag_next = mag_reg << 1;
            end
            LN_SQUARE:
            begin
                sq_next = mag_reg * mag_reg;
            end
            LN_DIV_START:
            begin
                rem_next  = DV_W'(num[NUM_W-1:QUO_W]);
                nlow_next = num[QUO_W-1:0];
                q_next    = '0;
            end
            LN_DIV_STEP:
            begin
                rem_next  = ge ? DV_W'(trial - dvs) : DV_W'(trial);
                nlow_next = nlow_reg << 1;
                q_next    = {q_reg[QUO_W-2:0], ge};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        nlow_reg <= nlow_next;
        q_reg    <= q_next;
    end

    // clamp to the q1.15 range of the sign
    always_comb
    begin
        if (neg_reg)
        begin
            q_sat = (q_reg > QUO_W'(32768)) ? QUO_W'(32768) : q_reg;
            res   = 16'(~q_sat + 1'b1);
        end
        else
        begin
            q_sat = (q_reg > QUO_W'(32767)) ? QUO_W'(32767) : q_reg;
            res   = 16'(q_sat);
        end
    end

    assign high     = |mag_reg[NW-1:NORM_BIT];
    assign sum_zero = (sum_reg == '0);
    assign sq       = sq_reg;
endmodule
`default_nettype wire

>>> hdl/qma_root.sv
// bit-serial integer square root, one result bit per cycle
`default_nettype none
module qma_root #(
    parameter int RW = 26
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2*RW-1:0] n,
    output logic      [RW-1:0]   len,
    output logic                 done
);
    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] n_reg, n_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [RW+3:0]   cur, trial;
    logic            ge;

    assign cur   = {rem_reg, n_reg[2*RW-1:2*RW-2]};
    assign trial = (RW + 4)'({root_reg, 2'b01});
    assign ge    = cur >= trial;

    always_comb
    begin
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = n;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (RW + 2)'(cur - trial) : (RW + 2)'(cur);
            root_next = {root_reg[RW-2:0], ge};
            n_next    = n_reg << 2;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign len  = root_reg;
    assign done = done_reg;
endmodule
`default_nettype wire
